[hw/rtl/rectangle_pixel_rasterizer_unit_defines.svh]
// Assertion macros used by the rectangle rasterizer RTL.
`ifndef RECTANGLE_PIXEL_RASTERIZER_UNIT_DEFINES_SVH
`define RECTANGLE_PIXEL_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RPR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rasterizer check failed");

// Next-cycle implication, checked out of reset.
`define RPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rasterizer check failed");

`endif

[hw/rtl/rpr_pkg.sv]
// Shared types and constants of the rectangle pixel rasterizer.
`timescale 1ns / 1ps
package rpr_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int SIZE_BITS          = 13;
    localparam int STRIDE_BITS        = 14;
    localparam int ADDR_BITS          = 32;
    localparam int COLOR_BITS         = 16;
    localparam int PROD_BITS          = SIZE_BITS + STRIDE_BITS;
    localparam int OP_BITS            = 2;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 32;

    localparam int OUT_USED_BITS = ADDR_BITS + COLOR_BITS + 1;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_USED_BITS;

    localparam logic [SIZE_BITS-1:0]   SCREEN_WIDTH_RESET  = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0]   SCREEN_HEIGHT_RESET = SIZE_BITS'(480);
    localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RESET    = STRIDE_BITS'(1280);
    localparam logic [ADDR_BITS-1:0]   FRAME_BASE_RESET    = '0;

    typedef enum logic [OP_BITS-1:0] {
        OP_START_FILL    = 2'd0,
        OP_START_OUTLINE = 2'd1,
        OP_STEP          = 2'd2,
        OP_NONE          = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_ROW_STRIDE    = 2'd2,
        CFG_FRAME_BASE    = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        WS_IDLE   = 5'b00001,
        WS_FILL   = 5'b00010,
        WS_TOP    = 5'b00100,
        WS_SIDES  = 5'b01000,
        WS_BOTTOM = 5'b10000
    } walk_state_t;

    typedef struct packed {
        logic write_enable;
        logic last_pixel;
        logic busy_res;
    } pix_flags_t;

endpackage

[hw/rtl/rpr_walker.sv]
// Rectangle walker: latches the command and picks the next pixel coordinate.
`timescale 1ns / 1ps
module rpr_walker
    import rpr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic [OP_BITS-1:0]           opcode,
    input  logic signed [COORD_BITS-1:0] corner_x,
    input  logic signed [COORD_BITS-1:0] corner_y,
    input  logic signed [COORD_BITS-1:0] rect_width,
    input  logic signed [COORD_BITS-1:0] rect_height,
    input  logic [COLOR_BITS-1:0]        fill_color,
    output logic signed [COORD_BITS:0]   px,
    output logic signed [COORD_BITS:0]   py,
    output logic [COLOR_BITS-1:0]        color,
    output pix_flags_t                   flags
);

    walk_state_t                  state_reg, state_next;
    logic [COORD_BITS-1:0]        walk_x_reg, walk_x_next;
    logic [COORD_BITS-1:0]        walk_y_reg, walk_y_next;
    logic [COORD_BITS-1:0]        span_w_reg, span_w_next;
    logic [COORD_BITS-1:0]        span_h_reg, span_h_next;
    logic signed [COORD_BITS-1:0] left_x_reg, left_x_next;
    logic signed [COORD_BITS-1:0] top_y_reg, top_y_next;
    logic [COLOR_BITS-1:0]        held_color_reg, held_color_next;
    logic                         side_right_reg, side_right_next;

    logic signed [COORD_BITS:0]   px_reg, px_next;
    logic signed [COORD_BITS:0]   py_reg, py_next;
    logic [COLOR_BITS-1:0]        color_reg;
    pix_flags_t                   flags_reg, flags_next;

    logic [COORD_BITS-1:0]        x_off, y_off;
    logic [COORD_BITS-1:0]        wx_inc, wy_inc;
    logic                         wx_end, wy_end;
    logic                         size_ok;

    assign wx_inc  = walk_x_reg + 1'b1;
    assign wy_inc  = walk_y_reg + 1'b1;
    assign wx_end  = (wx_inc == span_w_reg);
    assign wy_end  = (wy_inc == span_h_reg);
    assign size_ok = !rect_width[COORD_BITS-1] && (rect_width != '0) &&
                     !rect_height[COORD_BITS-1] && (rect_height != '0);

    always_comb begin
        state_next      = state_reg;
        walk_x_next     = walk_x_reg;
        walk_y_next     = walk_y_reg;
        span_w_next     = span_w_reg;
        span_h_next     = span_h_reg;
        left_x_next     = left_x_reg;
        top_y_next      = top_y_reg;
        held_color_next = held_color_reg;
        side_right_next = side_right_reg;
        flags_next      = '0;
        x_off           = '0;
        y_off           = '0;

        case (opcode_t'(opcode))
            OP_START_FILL, OP_START_OUTLINE: begin
                held_color_next = fill_color;
                left_x_next     = corner_x;
                top_y_next      = corner_y;
                walk_x_next     = '0;
                walk_y_next     = '0;
                side_right_next = 1'b0;
                if (size_ok) begin
                    span_w_next         = rect_width;
                    span_h_next         = rect_height;
                    state_next          = (opcode_t'(opcode) == OP_START_OUTLINE) ?
                                          WS_TOP : WS_FILL;
                    flags_next.busy_res = 1'b1;
                end else begin
                    span_w_next = '0;
                    span_h_next = '0;
                    state_next  = WS_IDLE;
                end
            end
            OP_STEP: begin
                flags_next.write_enable = (state_reg != WS_IDLE);
                flags_next.busy_res     = (state_reg != WS_IDLE);
                case (state_reg)
                    WS_FILL: begin
                        x_off       = walk_x_reg;
                        y_off       = walk_y_reg;
                        walk_x_next = wx_inc;
                        if (wx_end) begin
                            walk_x_next = '0;
                            walk_y_next = wy_inc;
                            if (wy_end) begin
                                state_next            = WS_IDLE;
                                flags_next.last_pixel = 1'b1;
                                flags_next.busy_res   = 1'b0;
                            end
                        end
                    end
                    WS_TOP: begin
                        x_off       = walk_x_reg;
                        walk_x_next = wx_inc;
                        if (wx_end) begin
                            walk_x_next     = '0;
                            walk_y_next     = '0;
                            side_right_next = 1'b0;
                            state_next      = WS_SIDES;
                        end
                    end
                    WS_SIDES: begin
                        x_off = side_right_reg ? span_w_reg : '0;
                        y_off = walk_y_reg;
                        if (!side_right_reg) begin
                            side_right_next = 1'b1;
                        end else begin
                            side_right_next = 1'b0;
                            walk_y_next     = wy_inc;
                            if (wy_end) begin
                                walk_x_next = '0;
                                state_next  = WS_BOTTOM;
                            end
                        end
                    end
                    WS_BOTTOM: begin
                        x_off       = walk_x_reg;
                        y_off       = span_h_reg - 1'b1;
                        walk_x_next = wx_inc;
                        if (wx_end) begin
                            state_next            = WS_IDLE;
                            flags_next.last_pixel = 1'b1;
                            flags_next.busy_res   = 1'b0;
                        end
                    end
                    default: begin
                        flags_next = '0;
                    end
                endcase
            end
            default: begin
                flags_next.busy_res = (state_reg != WS_IDLE);
            end
        endcase

        px_next = $signed({left_x_reg[COORD_BITS-1], left_x_reg}) + $signed({1'b0, x_off});
        py_next = $signed({top_y_reg[COORD_BITS-1], top_y_reg}) + $signed({1'b0, y_off});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= WS_IDLE;
        end else if (load) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            walk_x_reg     <= walk_x_next;
            walk_y_reg     <= walk_y_next;
            span_w_reg     <= span_w_next;
            span_h_reg     <= span_h_next;
            left_x_reg     <= left_x_next;
            top_y_reg      <= top_y_next;
            held_color_reg <= held_color_next;
            side_right_reg <= side_right_next;
            px_reg         <= px_next;
            py_reg         <= py_next;
            color_reg      <= held_color_reg;
            flags_reg      <= flags_next;
        end
    end

    assign px    = px_reg;
    assign py    = py_reg;
    assign color = color_reg;
    assign flags = flags_reg;

endmodule

[hw/rtl/rpr_addr.sv]
// Address stage: clamps the pixel to the screen and forms its byte address.
`timescale 1ns / 1ps
module rpr_addr
    import rpr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       load,
    input  logic signed [COORD_BITS:0] px,
    input  logic signed [COORD_BITS:0] py,
    input  logic [COLOR_BITS-1:0]      color_in,
    input  pix_flags_t                 flags_in,
    input  logic [SIZE_BITS-1:0]       screen_width,
    input  logic [SIZE_BITS-1:0]       screen_height,
    input  logic [STRIDE_BITS-1:0]     row_stride,
    input  logic [ADDR_BITS-1:0]       frame_base,
    output logic [ADDR_BITS-1:0]       pixel_address,
    output logic [COLOR_BITS-1:0]      pixel_color,
    output pix_flags_t                 flags_out
);

    localparam int UW = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;

    function automatic logic [SIZE_BITS-1:0] clamp_coord(
        input logic signed [COORD_BITS:0] v,
        input logic [SIZE_BITS-1:0]       size
    );
        logic [UW-1:0]        mag;
        logic [UW-1:0]        hi;
        logic [SIZE_BITS-1:0] res;
        hi  = (size == '0) ? '0 : UW'(size - 1'b1);
        mag = UW'(v[COORD_BITS-1:0]);
        if (v[COORD_BITS]) begin
            res = '0;
        end else if (mag > hi) begin
            res = SIZE_BITS'(hi);
        end else begin
            res = SIZE_BITS'(mag);
        end
        return res;
    endfunction

    logic [SIZE_BITS-1:0]  cx, cy;
    logic [PROD_BITS-1:0]  row_offset;
    logic [ADDR_BITS-1:0]  addr_next;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [COLOR_BITS-1:0] color_reg;
    pix_flags_t            flags_reg;

    assign cx         = clamp_coord(px, screen_width);
    assign cy         = clamp_coord(py, screen_height);
    assign row_offset = cy * row_stride;
    assign addr_next  = frame_base + ADDR_BITS'(row_offset) + ADDR_BITS'({cx, 1'b0});

    // Results without a write carry zero address and color.
    always_ff @(posedge aclk) begin
        if (load) begin
            addr_reg  <= flags_in.write_enable ? addr_next : '0;
            color_reg <= flags_in.write_enable ? color_in : '0;
            flags_reg <= flags_in;
        end
    end

    assign pixel_address = addr_reg;
    assign pixel_color   = color_reg;
    assign flags_out     = flags_reg;

endmodule

[hw/rtl/rectangle_pixel_rasterizer_unit.sv]
// Rectangle pixel rasterizer: a start transfer latches a filled or outline rectangle and each
// step transfer returns one clamped pixel write (address base + y*stride + 2*x); every input
// transfer gives exactly one result transfer, in order. Throughput is one item per clock while
// the output does not stall, set by the walker, which updates its position in the same cycle
// it takes an item; a result passes the walker register, loaded at the input transfer, and
// then the clamp and 13x14 multiply-add address register, loaded when the output register is
// free or drains. Output backpressure stalls the input only once both registers hold items.
// Write the configuration only while no item is in flight.
`timescale 1ns / 1ps
`include "rectangle_pixel_rasterizer_unit_defines.svh"
module rectangle_pixel_rasterizer_unit
    import rpr_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEFAULT,
    localparam int IN_DATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // corner_x, corner_y, rect_width, rect_height, fill_color
    input  logic [IN_DATA_BITS-1:0]   s_tdata,
    input  logic [OP_BITS-1:0]        s_tuser,  // opcode
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata,  // pixel_address, pixel_color, busy_res
    output logic                      m_tuser,  // write_enable
    output logic                      m_tlast   // last_pixel
);

    logic [SIZE_BITS-1:0]   screen_width_reg;
    logic [SIZE_BITS-1:0]   screen_height_reg;
    logic [STRIDE_BITS-1:0] row_stride_reg;
    logic [ADDR_BITS-1:0]   frame_base_reg;

    logic       p1_valid_reg;
    logic       m_valid_reg;
    logic       s_accept;
    logic       p2_load;

    logic signed [COORD_BITS:0] walk_px, walk_py;
    logic [COLOR_BITS-1:0]      walk_color;
    pix_flags_t                 walk_flags;

    logic [ADDR_BITS-1:0]  out_address;
    logic [COLOR_BITS-1:0] out_color;
    pix_flags_t            out_flags;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
            row_stride_reg    <= ROW_STRIDE_RESET;
            frame_base_reg    <= FRAME_BASE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SIZE_BITS-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SIZE_BITS-1:0];
                CFG_ROW_STRIDE:    row_stride_reg    <= cfg_data[STRIDE_BITS-1:0];
                CFG_FRAME_BASE:    frame_base_reg    <= cfg_data[ADDR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the address stage whenever the output register is free or drains.
    assign p2_load  = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p2_load;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p2_load) begin
                p1_valid_reg <= 1'b0;
            end
            if (p2_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    rpr_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (s_accept),
        .opcode      (s_tuser),
        .corner_x    ($signed(s_tdata[COORD_BITS-1:0])),
        .corner_y    ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
        .rect_width  ($signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS])),
        .rect_height ($signed(s_tdata[4*COORD_BITS-1:3*COORD_BITS])),
        .fill_color  (s_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS]),
        .px          (walk_px),
        .py          (walk_py),
        .color       (walk_color),
        .flags       (walk_flags)
    );

    rpr_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .aclk          (aclk),
        .load          (p2_load),
        .px            (walk_px),
        .py            (walk_py),
        .color_in      (walk_color),
        .flags_in      (walk_flags),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .row_stride    (row_stride_reg),
        .frame_base    (frame_base_reg),
        .pixel_address (out_address),
        .pixel_color   (out_color),
        .flags_out     (out_flags)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, out_flags.busy_res, out_color, out_address};
    assign m_tuser  = out_flags.write_enable;
    assign m_tlast  = out_flags.last_pixel;

    `RPR_ASSERT_IMPL(a_last_is_write, aclk, aresetn, m_tvalid && m_tlast, m_tuser)
    `RPR_ASSERT_IMPL(a_last_not_busy, aclk, aresetn, m_tvalid && m_tlast, !out_flags.busy_res)
    `RPR_ASSERT_IMPL(a_mid_busy, aclk, aresetn, m_tvalid && m_tuser && !m_tlast, out_flags.busy_res)
    `RPR_ASSERT_IMPL(a_ready_when_drained, aclk, aresetn, !m_valid_reg, s_tready)

endmodule

[tb/tb_rectangle_pixel_rasterizer_unit.sv]
// Self-checking testbench for the rectangle pixel rasterizer unit.
`timescale 1ns / 1ps
module tb_rectangle_pixel_rasterizer_unit;
    import rpr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 250;
    localparam int WALK_CAP    = 40;

    localparam logic [1:0] RUN_TOP    = 2'd0;
    localparam logic [1:0] RUN_SIDES  = 2'd1;
    localparam logic [1:0] RUN_BOTTOM = 2'd2;

    typedef struct packed {
        opcode_t            op;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [15:0]        color;
    } rect_cmd_t;

    typedef struct packed {
        logic        we;
        logic [31:0] addr;
        logic [15:0] color;
        logic        last;
        logic        busy;
    } pixel_write_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [79:0]       s_tdata = '0;  // corner_x, corner_y, rect_width, rect_height, fill_color
    logic [OP_BITS-1:0] s_tuser = '0; // opcode

    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;  // pixel_address, pixel_color, busy_res
    logic                     m_tuser;  // write_enable
    logic                     m_tlast;  // last_pixel

    rectangle_pixel_rasterizer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    rect_cmd_t    pending_cmds[$];
    pixel_write_t expected_writes[$];
    rect_cmd_t    bus_cmd;
    int           send_hold = 0;
    int           ready_hold = 0;
    bit           quiet = 1'b0;
    int           error_count = 0;
    int           cycle_count = 0;

    // screen setup as the block should see it
    logic [12:0] screen_w = 13'd640;
    logic [12:0] screen_h = 13'd480;
    logic [13:0] row_stride = 14'd1280;
    logic [31:0] frame_base = 32'd0;

    // rectangle walker state
    logic        walk_on = 1'b0;
    logic        outline_on = 1'b0;
    logic [1:0]  run_part = RUN_TOP;
    logic        right_side = 1'b0;
    int          step_x = 0;
    int          step_y = 0;
    int          span_w = 0;
    int          span_h = 0;
    longint      org_x = 0;
    longint      org_y = 0;
    logic [15:0] pen_color = '0;

    function automatic logic [31:0] clamp_axis(longint v, logic [12:0] size);
        longint hi;
        hi = (size == 0) ? 0 : longint'(size) - 1;
        if (v < 0) v = 0;
        if (v > hi) v = hi;
        return v[31:0];
    endfunction

    // Advance the walker by one item and return the pixel write it yields.
    function automatic pixel_write_t rasterize(rect_cmd_t c);
        pixel_write_t r;
        longint       px;
        longint       py;
        logic         done;
        r = '0;
        px = 0;
        py = 0;
        done = 1'b0;
        if (c.op == OP_START_FILL || c.op == OP_START_OUTLINE) begin
            org_x = c.cx;
            org_y = c.cy;
            pen_color = c.color;
            outline_on = (c.op == OP_START_OUTLINE);
            run_part = RUN_TOP;
            right_side = 1'b0;
            step_x = 0;
            step_y = 0;
            if (c.w <= 0 || c.h <= 0) begin
                walk_on = 1'b0;
                span_w = 0;
                span_h = 0;
            end else begin
                walk_on = 1'b1;
                span_w = int'(c.w);
                span_h = int'(c.h);
            end
            r.busy = walk_on;
            return r;
        end
        if (c.op == OP_NONE || !walk_on) begin
            r.busy = walk_on;
            return r;
        end
        if (!outline_on) begin
            px = org_x + step_x;
            py = org_y + step_y;
            step_x++;
            if (step_x >= span_w) begin
                step_x = 0;
                step_y++;
                if (step_y >= span_h) done = 1'b1;
            end
        end else if (run_part == RUN_TOP) begin
            px = org_x + step_x;
            py = org_y;
            step_x++;
            if (step_x >= span_w) begin
                step_x = 0;
                step_y = 0;
                right_side = 1'b0;
                run_part = RUN_SIDES;
            end
        end else if (run_part == RUN_SIDES) begin
            // right side lands one past the last column
            px = right_side ? org_x + span_w : org_x;
            py = org_y + step_y;
            if (!right_side) begin
                right_side = 1'b1;
            end else begin
                right_side = 1'b0;
                step_y++;
                if (step_y >= span_h) begin
                    step_x = 0;
                    run_part = RUN_BOTTOM;
                end
            end
        end else begin
            px = org_x + step_x;
            py = org_y + span_h - 1;
            step_x++;
            if (step_x >= span_w) done = 1'b1;
        end
        if (done) walk_on = 1'b0;
        r.we = 1'b1;
        r.addr = frame_base + clamp_axis(py, screen_h) * row_stride
               + 32'd2 * clamp_axis(px, screen_w);
        r.color = pen_color;
        r.last = done;
        r.busy = !done;
        return r;
    endfunction

    function automatic rect_cmd_t random_cmd(opcode_t op);
        rect_cmd_t c;
        c.op = op;
        c.cx = 16'($urandom);
        c.cy = 16'($urandom);
        c.w = 16'($urandom);
        c.h = 16'($urandom);
        c.color = 16'($urandom);
        return c;
    endfunction

    // Coordinate around the visible screen so that clamping hits both sides.
    function automatic logic [15:0] near_coord(logic [12:0] size);
        int v;
        v = int'($urandom_range(0, int'(size) + 15)) - 8;
        return v[15:0];
    endfunction

    task automatic push_cmd(opcode_t op, int cx, int cy, int w, int h, int color);
        rect_cmd_t c;
        c.op = op;
        c.cx = cx[15:0];
        c.cy = cy[15:0];
        c.w = w[15:0];
        c.h = h[15:0];
        c.color = color[15:0];
        pending_cmds.push_back(c);
    endtask

    // Start command followed by its steps; sometimes cut short, overrun or noisy.
    task automatic queue_rect_run(inout int counted);
        rect_cmd_t c;
        rect_cmd_t s;
        int        kind;
        int        steps;
        c = random_cmd($urandom_range(0, 1) ? OP_START_OUTLINE : OP_START_FILL);
        kind = $urandom_range(0, 99);
        if (kind < 14) begin
            if (kind < 4) c.w = -16'($urandom_range(0, 4));
            else if (kind < 8) c.h = -16'($urandom_range(0, 4));
        end else begin
            c.w = 16'($urandom_range(1, 6));
            c.h = 16'($urandom_range(1, 6));
        end
        if ($urandom_range(0, 3) != 0) begin
            c.cx = near_coord(screen_w);
            c.cy = near_coord(screen_h);
        end
        pending_cmds.push_back(c);
        counted++;
        if (c.w > 0 && c.h > 0) begin
            steps = (c.op == OP_START_OUTLINE) ? 2 * int'(c.w) + 2 * int'(c.h)
                                               : int'(c.w) * int'(c.h);
            if (steps > WALK_CAP) steps = WALK_CAP;
            if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
            steps += $urandom_range(0, 1);
        end else begin
            steps = $urandom_range(0, 2);
        end
        repeat (steps) begin
            s = random_cmd(($urandom_range(0, 19) == 0) ? OP_NONE : OP_STEP);
            pending_cmds.push_back(s);
            if (s.op != OP_NONE) counted++;
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:  screen_w = val[12:0];
            CFG_SCREEN_HEIGHT: screen_h = val[12:0];
            CFG_ROW_STRIDE:    row_stride = val[13:0];
            CFG_FRAME_BASE:    frame_base = val;
            default: begin
            end
        endcase
    endtask

    task automatic program_screen(int w, int h, int stride, logic [31:0] base);
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        write_reg(CFG_ROW_STRIDE, stride);
        write_reg(CFG_FRAME_BASE, base);
    endtask

    // Sample at the falling edge so the driver and monitor updates have settled.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_writes.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // input driver: predict on each transfer, then present the next command
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_writes.push_back(rasterize(bus_cmd));
            if (!s_tvalid || s_tready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    bus_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {bus_cmd.color, bus_cmd.h, bus_cmd.w, bus_cmd.cy, bus_cmd.cx};
                    s_tuser <= bus_cmd.op;
                    if (!quiet && $urandom_range(0, 9) == 0) send_hold = $urandom_range(1, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge aclk) begin
        pixel_write_t exp_w;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_writes.size() == 0) begin
                    $error("result transfer with no pending expectation");
                    error_count++;
                end else begin
                    exp_w = expected_writes.pop_front();
                    if (m_tuser !== exp_w.we) begin
                        $error("write_enable: expected %0b, got %0b", exp_w.we, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[31:0] !== exp_w.addr) begin
                        $error("pixel_address: expected %h, got %h", exp_w.addr, m_tdata[31:0]);
                        error_count++;
                    end
                    if (m_tdata[47:32] !== exp_w.color) begin
                        $error("pixel_color: expected %h, got %h", exp_w.color, m_tdata[47:32]);
                        error_count++;
                    end
                    if (m_tlast !== exp_w.last) begin
                        $error("last_pixel: expected %0b, got %0b", exp_w.last, m_tlast);
                        error_count++;
                    end
                    if (m_tdata[48] !== exp_w.busy) begin
                        $error("busy_res: expected %0b, got %0b", exp_w.busy, m_tdata[48]);
                        error_count++;
                    end
                end
            end
            if (ready_hold > 0) begin
                ready_hold--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                ready_hold = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_rectangle_pixel_rasterizer_unit: done, errors");
            $finish;
        end
    end

    initial begin
        int counted;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle step, ignored opcode, clamping at both screen edges,
        // empty rectangles, start while busy, single-pixel outline
        push_cmd(OP_STEP, -1, -1, -1, -1, 'hFFFF);
        push_cmd(OP_NONE, 0, 0, 0, 0, 0);
        push_cmd(OP_START_FILL, -1, -1, 2, 2, 'hFFFF);
        repeat (4) push_cmd(OP_STEP, 0, 0, 0, 0, 0);
        push_cmd(OP_START_OUTLINE, 638, 478, 2, 1, 'h1234);
        repeat (3) push_cmd(OP_STEP, 0, 0, 0, 0, 0);
        push_cmd(OP_NONE, -1, -1, -1, -1, 'hFFFF);
        repeat (3) push_cmd(OP_STEP, 0, 0, 0, 0, 0);
        push_cmd(OP_START_FILL, 5, 5, 0, 3, 'h00AA);
        push_cmd(OP_START_OUTLINE, 5, 5, 3, -32768, 'h00AA);
        push_cmd(OP_STEP, 0, 0, 0, 0, 0);
        push_cmd(OP_START_FILL, 32767, -32768, 32767, 32767, 0);
        push_cmd(OP_STEP, 0, 0, 0, 0, 0);
        push_cmd(OP_START_OUTLINE, 0, 0, 1, 1, 'h8001);
        repeat (4) push_cmd(OP_STEP, 0, 0, 0, 0, 0);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: program_screen(1, 1, 2, 32'd0);
                1: program_screen(4096, 4096, 8192, 32'hFFFF_FFFF);
                2: program_screen(0, 0, $urandom_range(2, 8192), $urandom);
                3: program_screen($urandom_range(1, 64), $urandom_range(1, 64),
                                  $urandom_range(2, 8192), $urandom);
                4: program_screen($urandom_range(1, 4096), $urandom_range(1, 4096),
                                  $urandom_range(2, 8192), $urandom);
                default: begin
                    program_screen($urandom_range(1, 200), $urandom_range(1, 200),
                                   $urandom_range(2, 8192), $urandom);
                    quiet = 1'b1;
                end
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS) queue_rect_run(counted);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (expected_writes.size() != 0) begin
            $error("%0d expected results never arrived", expected_writes.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_rectangle_pixel_rasterizer_unit: done, clean");
        end else begin
            $display("tb_rectangle_pixel_rasterizer_unit: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_walker.sv
hw/rtl/rpr_addr.sv
hw/rtl/rectangle_pixel_rasterizer_unit.sv
tb/tb_rectangle_pixel_rasterizer_unit.sv
